// ===== sv/bpfl_pkg.sv =====
package bpfl_pkg;

	// widths fixed by the ports
	localparam int IDX_W = 4;
	localparam int CMD_W = 2;
	localparam int ST_W  = 2;
	localparam int FC_W  = 5;

	localparam int NUM_BUFFERS_DEF = 16;
	localparam logic [FC_W-1:0] RESERVE_RESET = FC_W'(3);

	typedef enum logic [CMD_W-1:0] {
		CMD_GET     = 2'd0,
		CMD_GET_ISR = 2'd1,
		CMD_REL     = 2'd2,
		CMD_REL_ISR = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_RESERVE = 2'd2,
		ST_DOUBLE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

// ===== sv/bpfl_ctrl.sv =====
module bpfl_ctrl import bpfl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output ctrl_cmd_t ctl
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		ctl.load = 1'b0;
		ctl.exec = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == S_EXEC);

endmodule

// ===== sv/bpfl_dp.sv =====
module bpfl_dp import bpfl_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        ctl,
	input  logic [CMD_W-1:0] cmd,
	input  logic [IDX_W-1:0] buffer_index,
	input  logic             cfg_we,
	input  logic [FC_W-1:0]  cfg_wdata,
	output logic             done,
	output logic [IDX_W-1:0] granted_index,
	output logic [ST_W-1:0]  status,
	output logic [FC_W-1:0]  free_count
);

	localparam int PW = $clog2(NUM_BUFFERS);
	localparam int CW = $clog2(NUM_BUFFERS + 1);
	localparam logic [PW-1:0]    LAST_PTR = PW'(NUM_BUFFERS - 1);
	localparam logic [IDX_W:0]   NB_EXT   = (IDX_W + 1)'(NUM_BUFFERS);

	logic [CMD_W-1:0] cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] ring_q [NUM_BUFFERS];
	logic             free_q [NUM_BUFFERS];
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [CW-1:0]    total_q;
	logic [FC_W-1:0]  reserve_q;

	logic             done_q;
	logic [IDX_W-1:0] granted_q;
	logic [ST_W-1:0]  status_q;
	logic [FC_W-1:0]  count_q;

	logic             is_get;
	logic             do_get;
	logic             do_rel;
	logic             idx_ok;
	logic [IDX_W-1:0] head_word;
	logic             head_ok;
	logic [CW-1:0]    total_d;
	logic [ST_W-1:0]  status_d;
	logic [IDX_W-1:0] granted_d;

	always_comb begin
		is_get    = (cmd_q == CMD_GET) || (cmd_q == CMD_GET_ISR);
		head_word = ring_q[head_q];
		head_ok   = {1'b0, head_word} < NB_EXT;
		idx_ok    = {1'b0, idx_q} < NB_EXT;
		do_get    = 1'b0;
		do_rel    = 1'b0;
		status_d  = ST_OK;
		granted_d = '0;
		total_d   = total_q;
		if (is_get) begin
			if (total_q == '0) begin
				status_d = ST_EMPTY;
			end else if ((cmd_q == CMD_GET_ISR) && (FC_W'(total_q) <= reserve_q)) begin
				status_d = ST_RESERVE;
			end else begin
				do_get    = 1'b1;
				granted_d = head_word;
				total_d   = total_q - CW'(1);
			end
		end else begin
			// out-of-pool index is rejected like a second release
			if (!idx_ok || free_q[idx_q[PW-1:0]]) begin
				status_d = ST_DOUBLE;
			end else begin
				do_rel  = 1'b1;
				total_d = total_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			idx_q <= buffer_index;
		end
		if (ctl.exec) begin
			granted_q <= granted_d;
			status_q  <= status_d;
			count_q   <= FC_W'(total_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				ring_q[i] <= IDX_W'(i);
				free_q[i] <= 1'b1;
			end
			head_q    <= '0;
			tail_q    <= '0;
			total_q   <= CW'(NUM_BUFFERS);
			reserve_q <= RESERVE_RESET;
			done_q    <= 1'b0;
		end else begin
			done_q <= ctl.exec;
			if (cfg_we) begin
				reserve_q <= cfg_wdata;
			end
			if (ctl.exec) begin
				total_q <= total_d;
				if (do_get) begin
					if (head_ok) begin
						free_q[head_word[PW-1:0]] <= 1'b0;
					end
					head_q <= (head_q == LAST_PTR) ? '0 : head_q + PW'(1);
				end
				if (do_rel) begin
					ring_q[tail_q]        <= idx_q;
					free_q[idx_q[PW-1:0]] <= 1'b1;
					tail_q <= (tail_q == LAST_PTR) ? '0 : tail_q + PW'(1);
				end
			end
		end
	end

	assign done          = done_q;
	assign granted_index = granted_q;
	assign status        = status_q;
	assign free_count    = count_q;

endmodule

// ===== sv/buffer_pool_free_list_top.sv =====
// Channel   Handshake        Payload
// input     start / busy     cmd, buffer_index
// result    done (1 cycle)   granted_index, status, free_count
// config    cfg_we           cfg_wdata (isr_reserve)
//
// Each word goes through a capture step and then a ring/count update step.
// busy is high during the update cycle; the result is shown with done in the
// cycle after it, while a new word may already be taken.
// Reset leaves all buffers free, ring in index order, isr_reserve = 3.
// No stall on the result side: done lasts exactly one cycle.
module buffer_pool_free_list_top import bpfl_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CMD_W-1:0] cmd,
	input  logic [IDX_W-1:0] buffer_index,
	input  logic             cfg_we,
	input  logic [FC_W-1:0]  cfg_wdata,
	output logic             done,
	output logic [IDX_W-1:0] granted_index,
	output logic [ST_W-1:0]  status,
	output logic [FC_W-1:0]  free_count
);

	ctrl_cmd_t ctl;

	bpfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	bpfl_dp #(
		.NUM_BUFFERS (NUM_BUFFERS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (cmd),
		.buffer_index  (buffer_index),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.granted_index (granted_index),
		.status        (status),
		.free_count    (free_count)
	);

endmodule

// ===== sv/bpfl_chk.sv =====
module bpfl_chk import bpfl_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [IDX_W-1:0] granted_index,
	input logic [ST_W-1:0]  status,
	input logic [FC_W-1:0]  free_count
);

	localparam logic [FC_W-1:0] FC_MAX = FC_W'(NUM_BUFFERS);

	// an accepted word occupies exactly one update cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("update cycle not followed by a result");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a word in progress");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> free_count <= FC_MAX)
		else $error("free count above pool size");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> granted_index == '0)
		else $error("nonzero index on a failed word");

endmodule

bind buffer_pool_free_list_top bpfl_chk #(
	.NUM_BUFFERS (NUM_BUFFERS)
) u_bpfl_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.granted_index (granted_index),
	.status        (status),
	.free_count    (free_count)
);
